/* hdl/ed_pkg.sv */
// shared constants and controller/datapath command and status types
// for the edit distance alignment block; no dependencies
package ed_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int DW          = 7;

    localparam logic [1:0] ACT_APPEND_A = 2'd0;
    localparam logic [1:0] ACT_APPEND_B = 2'd1;
    localparam logic [1:0] ACT_RUN      = 2'd2;

    localparam logic [1:0] COST_GAP = 2'd2;

    typedef struct packed {
        logic accept_in;
        logic fill_rd;
        logic fill_wr;
        logic dist_rd;
        logic dist_cap;
        logic tb_rd_diag;
        logic tb_rd_down;
        logic tb_cap_down;
        logic tb_decide;
        logic load_empty;
        logic finish;
    } ed_cmd_t;

    typedef struct packed {
        logic both_empty;
        logic no_fill;
        logic fill_last;
        logic interior;
        logic last_col;
    } ed_sts_t;

endpackage

/* hdl/ed_if.sv */
// word channels of the alignment block: symbol input and column output
// depends on nothing
interface ed_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink (input valid, input action, input symbol, output ready);
endinterface

interface ed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] a_symbol;
    logic [7:0] b_symbol;
    logic       a_is_gap;
    logic       b_is_gap;
    logic [1:0] step_cost;
    logic [6:0] distance;
    logic       truncated;
    logic       empty_alignment;
    logic       last_column;

    modport source (output valid, output a_symbol, output b_symbol, output a_is_gap,
                    output b_is_gap, output step_cost, output distance, output truncated,
                    output empty_alignment, output last_column, input ready);
    modport sink (input valid, input a_symbol, input b_symbol, input a_is_gap,
                  input b_is_gap, input step_cost, input distance, input truncated,
                  input empty_alignment, input last_column, output ready);
endinterface

/* hdl/edit_distance_align_top.sv */
// top level of the edit distance alignment block
// depends on ed_pkg, ed_if, ed_ctrl and ed_datapath
//
//  channel  dir  word
//  item     in   action, symbol
//  result   out  a_symbol, b_symbol, a_is_gap, b_is_gap, step_cost, distance,
//                truncated, empty_alignment, last_column
//
// an append is taken in the idle state; a run of lengths m and n fills the cost
// memory with a read and a write state per cell, reads the distance with a read
// and a capture state, then traces each column with check and decide states, plus
// diagonal read, down read and capture inside the table, set by the single read port
// a column waits in the result register until taken; no item is taken during a run
// reset empties both strings and clears the truncation flag; no clearing pass
module edit_distance_align_top
    import ed_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    ed_in_if.sink  item,
    ed_out_if.source result
);

    ed_cmd_t cmd;
    ed_sts_t sts;

    ed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .action    (item.action),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ed_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (item.action),
        .symbol          (item.symbol),
        .a_symbol        (result.a_symbol),
        .b_symbol        (result.b_symbol),
        .a_is_gap        (result.a_is_gap),
        .b_is_gap        (result.b_is_gap),
        .step_cost       (result.step_cost),
        .distance        (result.distance),
        .truncated       (result.truncated),
        .empty_alignment (result.empty_alignment),
        .last_column     (result.last_column)
    );

endmodule

/* hdl/ed_datapath.sv */
// string stores, suffix cost memory, fill and traceback arithmetic, result register
// depends on ed_pkg
module ed_datapath
    import ed_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ed_cmd_t    cmd,
    output ed_sts_t    sts,
    input  logic [1:0] action,
    input  logic [7:0] symbol,
    output logic [7:0] a_symbol,
    output logic [7:0] b_symbol,
    output logic       a_is_gap,
    output logic       b_is_gap,
    output logic [1:0] step_cost,
    output logic [6:0] distance,
    output logic       truncated,
    output logic       empty_alignment,
    output logic       last_column
);

    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 2 ** AW;

    logic [7:0]    a_mem [MAX_LEN];
    logic [7:0]    b_mem [MAX_LEN];
    logic [DW-1:0] cost_mem [DEPTH];
    logic [DW-1:0] rdata_reg;
    logic [AW-1:0] rd_addr;

    logic [LW-1:0] len_a_reg, len_b_reg, i_reg, j_reg;
    logic          ovf_reg;
    logic [DW-1:0] diag_reg, right_reg, down_reg, here_reg, dist_reg;
    logic          last_reg;

    logic [LW-1:0] i_inc, j_inc, i_next, j_next;
    logic [7:0]    a_cur, b_cur;
    logic          pen, interior, take_diag, take_del;
    logic [DW-1:0] down_v, diag_v, cand_diag, cand_down, cand_right, best, here_next;

    function automatic logic [DW-1:0] dbl(input logic [LW-1:0] x);
        return DW'({x, 1'b0});
    endfunction

    assign i_inc = i_reg + 1'b1;
    assign j_inc = j_reg + 1'b1;
    assign a_cur = a_mem[i_reg[IW-1:0]];
    assign b_cur = b_mem[j_reg[IW-1:0]];
    assign pen   = (a_cur != b_cur);
    assign interior = (i_reg < len_a_reg) && (j_reg < len_b_reg);

    // value below the current cell, boundary row computed rather than stored
    assign down_v = (i_inc == len_a_reg) ? dbl(len_b_reg - j_reg) : rdata_reg;
    assign diag_v = (i_inc == len_a_reg) ? dbl(len_b_reg - j_inc) :
                    (j_inc == len_b_reg) ? dbl(len_a_reg - i_inc) : rdata_reg;

    assign cand_diag  = diag_reg + DW'(pen);
    assign cand_down  = down_v + DW'(2);
    assign cand_right = right_reg + DW'(2);

    always_comb
    begin
        best = cand_diag;
        if (cand_down < best)
        begin
            best = cand_down;
        end
        if (cand_right < best)
        begin
            best = cand_right;
        end
    end

    assign take_diag = interior && (here_reg == diag_reg + DW'(pen));
    assign take_del  = !take_diag && (i_reg < len_a_reg) &&
                       ((j_reg >= len_b_reg) || (here_reg == down_reg + DW'(2)));

    always_comb
    begin
        i_next    = i_reg;
        j_next    = j_reg;
        here_next = here_reg - DW'(2);
        if (take_diag)
        begin
            i_next    = i_inc;
            j_next    = j_inc;
            here_next = diag_reg;
        end
        else if (take_del)
        begin
            i_next = i_inc;
            if (interior)
            begin
                here_next = down_reg;
            end
        end
        else
        begin
            j_next = j_inc;
        end
    end

    always_comb
    begin
        rd_addr = '0;
        if (cmd.fill_rd || cmd.tb_rd_down)
        begin
            rd_addr = {i_inc[IW-1:0], j_reg[IW-1:0]};
        end
        else if (cmd.tb_rd_diag)
        begin
            rd_addr = {i_inc[IW-1:0], j_inc[IW-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= cost_mem[rd_addr];
        if (cmd.fill_wr)
        begin
            cost_mem[{i_reg[IW-1:0], j_reg[IW-1:0]}] <= best;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_in && action == ACT_APPEND_A && len_a_reg < LW'(MAX_LEN))
        begin
            a_mem[len_a_reg[IW-1:0]] <= symbol;
        end
        if (cmd.accept_in && action == ACT_APPEND_B && len_b_reg < LW'(MAX_LEN))
        begin
            b_mem[len_b_reg[IW-1:0]] <= symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept_in)
            begin
                unique case (action)
                    ACT_APPEND_A:
                    begin
                        if (len_a_reg < LW'(MAX_LEN))
                            len_a_reg <= len_a_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                    end
                    ACT_APPEND_B:
                    begin
                        if (len_b_reg < LW'(MAX_LEN))
                            len_b_reg <= len_b_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                    end
                    ACT_RUN:
                    begin
                        i_reg <= len_a_reg - 1'b1;
                        j_reg <= len_b_reg - 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.fill_wr)
            begin
                if (j_reg == '0)
                begin
                    i_reg <= i_reg - 1'b1;
                    j_reg <= len_b_reg - 1'b1;
                end
                else
                begin
                    j_reg <= j_reg - 1'b1;
                end
            end
            if (cmd.dist_cap)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            if (cmd.tb_decide)
            begin
                i_reg    <= i_next;
                j_reg    <= j_next;
                last_reg <= (i_next == len_a_reg) && (j_next == len_b_reg);
            end
            if (cmd.load_empty)
            begin
                last_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // working values and result word
    always_ff @(posedge clk)
    begin
        if (cmd.accept_in)
        begin
            diag_reg  <= '0;
            right_reg <= DW'(2);
        end
        if (cmd.fill_wr)
        begin
            if (j_reg == '0)
            begin
                diag_reg  <= dbl(len_a_reg - i_reg);
                right_reg <= dbl(len_a_reg - i_reg + 1'b1);
            end
            else
            begin
                diag_reg  <= down_v;
                right_reg <= best;
            end
        end
        if (cmd.dist_cap)
        begin
            if (len_a_reg == '0)
            begin
                dist_reg <= dbl(len_b_reg);
                here_reg <= dbl(len_b_reg);
            end
            else if (len_b_reg == '0)
            begin
                dist_reg <= dbl(len_a_reg);
                here_reg <= dbl(len_a_reg);
            end
            else
            begin
                dist_reg <= rdata_reg;
                here_reg <= rdata_reg;
            end
        end
        if (cmd.tb_rd_down)
        begin
            diag_reg <= diag_v;
        end
        if (cmd.tb_cap_down)
        begin
            down_reg <= down_v;
        end
        if (cmd.tb_decide)
        begin
            here_reg        <= here_next;
            a_symbol        <= (take_diag || take_del) ? a_cur : 8'd0;
            b_symbol        <= take_del ? 8'd0 : b_cur;
            a_is_gap        <= !(take_diag || take_del);
            b_is_gap        <= take_del;
            step_cost       <= take_diag ? {1'b0, pen} : COST_GAP;
            distance        <= dist_reg;
            truncated       <= ovf_reg;
            empty_alignment <= 1'b0;
        end
        if (cmd.load_empty)
        begin
            a_symbol        <= 8'd0;
            b_symbol        <= 8'd0;
            a_is_gap        <= 1'b0;
            b_is_gap        <= 1'b0;
            step_cost       <= 2'd0;
            distance        <= '0;
            truncated       <= ovf_reg;
            empty_alignment <= 1'b1;
        end
    end

    assign last_column    = last_reg;
    assign sts.both_empty = (len_a_reg == '0) && (len_b_reg == '0);
    assign sts.no_fill    = (len_a_reg == '0) || (len_b_reg == '0);
    assign sts.fill_last  = (i_reg == '0) && (j_reg == '0);
    assign sts.interior   = interior;
    assign sts.last_col   = last_reg;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_wr |-> (i_reg < len_a_reg) && (j_reg < len_b_reg))
        else $error("fill write outside the string bounds");

    a_tb_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tb_decide |-> (i_reg < len_a_reg) || (j_reg < len_b_reg))
        else $error("traceback step past the end of both strings");

    a_here_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tb_decide |-> here_reg <= dist_reg)
        else $error("remaining cost above total distance");

endmodule

/* hdl/ed_ctrl.sv */
// sequencer for symbol loads, table fill, distance read and traceback
// depends on ed_pkg
module ed_ctrl
    import ed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    output logic       out_valid,
    input  logic       out_ready,
    output ed_cmd_t    cmd,
    input  ed_sts_t    sts
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FILL_RD  = 4'd1;
    localparam logic [3:0] S_FILL_WR  = 4'd2;
    localparam logic [3:0] S_DIST_RD  = 4'd3;
    localparam logic [3:0] S_DIST_CAP = 4'd4;
    localparam logic [3:0] S_TB_CHECK = 4'd5;
    localparam logic [3:0] S_TB_DIAG  = 4'd6;
    localparam logic [3:0] S_TB_DOWN  = 4'd7;
    localparam logic [3:0] S_TB_CAP   = 4'd8;
    localparam logic [3:0] S_TB_DEC   = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept_in = 1'b1;
                    if (action == ACT_RUN)
                    begin
                        if (sts.both_empty)
                        begin
                            cmd.load_empty = 1'b1;
                            state_next     = S_OUT;
                        end
                        else if (sts.no_fill)
                            state_next = S_DIST_RD;
                        else
                            state_next = S_FILL_RD;
                    end
                end
            end
            S_FILL_RD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = sts.fill_last ? S_DIST_RD : S_FILL_RD;
            end
            S_DIST_RD:
            begin
                cmd.dist_rd = 1'b1;
                state_next  = S_DIST_CAP;
            end
            S_DIST_CAP:
            begin
                cmd.dist_cap = 1'b1;
                state_next   = S_TB_CHECK;
            end
            S_TB_CHECK:
            begin
                state_next = sts.interior ? S_TB_DIAG : S_TB_DEC;
            end
            S_TB_DIAG:
            begin
                cmd.tb_rd_diag = 1'b1;
                state_next     = S_TB_DOWN;
            end
            S_TB_DOWN:
            begin
                cmd.tb_rd_down = 1'b1;
                state_next     = S_TB_CAP;
            end
            S_TB_CAP:
            begin
                cmd.tb_cap_down = 1'b1;
                state_next      = S_TB_DEC;
            end
            S_TB_DEC:
            begin
                cmd.tb_decide = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.last_col)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_TB_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
